### hw/rtl/srtn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srtn_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 16;
  localparam int ID_BITS     = 8;

  localparam int CMD_BITS = 2;

  localparam logic [CMD_BITS-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_KEEP   = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_RETIRE = 2'd2;

  // per-beat result flags handed from the sequencer to the output stage
  typedef struct packed {
    logic preempted;
    logic full;
  } srtn_flags_t;

endpackage

`default_nettype wire

### hw/rtl/srtn_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module srtn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/srtn_core.sv
`timescale 1ns / 1ps
`default_nettype none

module srtn_core #(
  parameter int QUEUE_DEPTH = srtn_pkg::QUEUE_DEPTH,
  parameter int TIME_BITS   = srtn_pkg::TIME_BITS,
  parameter int ID_BITS     = srtn_pkg::ID_BITS,
  localparam int QW = $clog2(QUEUE_DEPTH + 1),
  localparam int AW = $clog2(QUEUE_DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [srtn_pkg::CMD_BITS-1:0] cmd,
  input  wire logic [ID_BITS-1:0]            id,
  input  wire logic [TIME_BITS-1:0]          t,
  input  wire logic                          res_free,
  output logic                               idle,
  output logic                               done,
  output srtn_pkg::srtn_flags_t              flags,
  output logic                               run_valid,
  output logic [ID_BITS-1:0]                 run_id,
  output logic [TIME_BITS-1:0]               run_time,
  output logic [QW-1:0]                      fill
);

  localparam int SW = AW + 1;
  localparam int EW = ID_BITS + TIME_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HEAD = 3'd1;
  localparam logic [2:0] S_HCHK = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_ICMP = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]           state;
  logic                 mode_keep;
  logic [ID_BITS-1:0]   key_id;
  logic [TIME_BITS-1:0] key_t;
  logic [AW-1:0]        head;
  logic [AW-1:0]        wp;
  logic [QW-1:0]        k;

  logic                 we;
  logic [AW-1:0]        waddr;
  logic [EW-1:0]        wdata;
  logic [AW-1:0]        raddr;
  logic [EW-1:0]        rdata;
  logic [TIME_BITS-1:0] rd_time;
  logic [ID_BITS-1:0]   rd_id;
  logic                 lt;
  logic [SW-1:0]        tail_sum;
  logic [AW-1:0]        tail;
  logic [AW-1:0]        head_inc;
  logic [AW-1:0]        wp_dec;

  srtn_ram #(
    .WIDTH(EW),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_time = rdata[TIME_BITS-1:0];
  assign rd_id   = rdata[TIME_BITS +: ID_BITS];

  // the one compare unit, shared by the head check and the insertion walk
  assign lt = rd_time < key_t;

  // ring buffer: slot of logical position fill
  assign tail_sum = {1'b0, head} + SW'(fill);
  assign tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ?
                    AW'(tail_sum - SW'(QUEUE_DEPTH)) : AW'(tail_sum);
  assign head_inc = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
  assign wp_dec   = (wp == '0) ? AW'(QUEUE_DEPTH - 1) : wp - AW'(1);

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE) && res_free;

  always_comb begin
    we    = 1'b0;
    waddr = wp;
    wdata = {key_id, key_t};
    raddr = (state == S_HEAD) ? head : wp_dec;
    case (state)
      S_INS: begin
        we = (k == '0);
      end
      S_ICMP: begin
        we    = 1'b1;
        wdata = lt ? {key_id, key_t} : rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      head      <= '0;
      run_valid <= 1'b0;
      run_id    <= '0;
      run_time  <= '0;
      flags     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            key_id    <= id;
            key_t     <= t;
            flags     <= '0;
            mode_keep <= 1'b0;
            wp        <= tail;
            k         <= fill;
            case (cmd)
              srtn_pkg::CMD_ADD: begin
                if (fill == QW'(QUEUE_DEPTH)) begin
                  flags.full <= 1'b1;
                  state      <= S_DONE;
                end else begin
                  state <= S_INS;
                end
              end
              srtn_pkg::CMD_KEEP: begin
                if (run_valid) begin
                  run_time  <= t;
                  mode_keep <= 1'b1;
                end
                state <= (fill == '0) ? S_DONE : S_HEAD;
              end
              srtn_pkg::CMD_RETIRE: begin
                if (fill == '0) begin
                  run_valid <= 1'b0;
                  run_id    <= '0;
                  run_time  <= '0;
                  state     <= S_DONE;
                end else begin
                  state <= S_HEAD;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_HEAD: begin
          state <= S_HCHK;
        end
        S_HCHK: begin
          if (!mode_keep || lt) begin
            run_valid <= 1'b1;
            run_id    <= rd_id;
            run_time  <= rd_time;
            head      <= head_inc;
            fill      <= fill - QW'(1);
          end
          if (mode_keep && lt) begin
            // old running task goes back in; the tail slot is unchanged by the pop
            flags.preempted <= 1'b1;
            key_id          <= run_id;
            k               <= fill - QW'(1);
            state           <= S_INS;
          end else begin
            state <= S_DONE;
          end
        end
        S_INS: begin
          if (k == '0) begin
            fill  <= fill + QW'(1);
            state <= S_DONE;
          end else begin
            state <= S_ICMP;
          end
        end
        S_ICMP: begin
          if (lt) begin
            fill  <= fill + QW'(1);
            state <= S_DONE;
          end else begin
            wp    <= wp_dec;
            k     <= k - QW'(1);
            state <= S_INS;
          end
        end
        S_DONE: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/srtn_ready_queue_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  handshake             payload
// in       in   in_valid / in_ready   command, task_id, task_time
// out      out  out_valid / out_ready running_valid, running_id, running_time,
//                                     preempted, status, queue_count
//
// one command at a time through a single sequencer and a single time comparator
// over a ring-buffer queue in a ram with registered read
// add: walks the queue from the tail, one read and one compare/shift per entry
// moved up, until the walk stops on a shorter entry; a full add only sets status
// retire pops the head; keep with preemption pops it, then the re-insertion walk
// rst is synchronous and empties the queue and idles the running register
// a result waiting in the output register holds the next beat only at its end

module srtn_ready_queue_scheduler #(
  parameter int QUEUE_DEPTH = srtn_pkg::QUEUE_DEPTH,
  parameter int TIME_BITS   = srtn_pkg::TIME_BITS,
  parameter int ID_BITS     = srtn_pkg::ID_BITS,
  localparam int QW = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [srtn_pkg::CMD_BITS-1:0] command,
  input  wire logic [ID_BITS-1:0]            task_id,
  input  wire logic [TIME_BITS-1:0]          task_time,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               running_valid,
  output logic [ID_BITS-1:0]                 running_id,
  output logic [TIME_BITS-1:0]               running_time,
  output logic                               preempted,
  output logic                               status,
  output logic [QW-1:0]                      queue_count
);

  logic                  core_idle;
  logic                  core_done;
  logic                  res_free;
  srtn_pkg::srtn_flags_t core_flags;
  logic                  core_run_valid;
  logic [ID_BITS-1:0]    core_run_id;
  logic [TIME_BITS-1:0]  core_run_time;
  logic [QW-1:0]         core_fill;

  assign in_ready = core_idle;
  assign res_free = !out_valid || out_ready;

  srtn_core #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_BITS  (TIME_BITS),
    .ID_BITS    (ID_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (in_valid && in_ready),
    .cmd      (command),
    .id       (task_id),
    .t        (task_time),
    .res_free (res_free),
    .idle     (core_idle),
    .done     (core_done),
    .flags    (core_flags),
    .run_valid(core_run_valid),
    .run_id   (core_run_id),
    .run_time (core_run_time),
    .fill     (core_fill)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_done) begin
      running_valid <= core_run_valid;
      running_id    <= core_run_id;
      running_time  <= core_run_time;
      preempted     <= core_flags.preempted;
      status        <= core_flags.full;
      queue_count   <= core_fill;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (queue_count <= QW'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(preempted && status))
    else $error("drop and preemption in one beat");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !running_valid) |-> (running_id == '0 && running_time == '0))
    else $error("idle result carries a task");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat taken while busy");

  a_preempt_running: assert property (@(posedge clk) disable iff (rst)
    (out_valid && preempted) |-> running_valid)
    else $error("preemption without a running task");

endmodule

`default_nettype wire
